@@ design/dwmf_pkg.sv @@
// Shared constants and types for the parenthesis match finder.
`timescale 1ns / 1ps

package dwmf_pkg;

    localparam int MAX_LEN = 1024;
    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W   = ADDR_W + 1;
    localparam int IDX_W   = 10;
    localparam int SKIP_W  = 11;
    localparam int CNT_W   = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    typedef enum logic {
        CMD_APPEND = 1'b0,
        CMD_QUERY  = 1'b1
    } t_cmd;

    typedef struct packed {
        logic              clear;
        logic              push;
        logic              pop;
        logic [ADDR_W-1:0] data;
    } t_stk_ctl;

endpackage

@@ design/dwmf_stack.sv @@
// Position stack: top entry in a register, the rest in a memory with a registered read.
`timescale 1ns / 1ps

module dwmf_stack (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  dwmf_pkg::t_stk_ctl      i_ctl,
    output logic [dwmf_pkg::ADDR_W-1:0] o_top,
    output logic [dwmf_pkg::LEN_W-1:0]  o_depth
);
    import dwmf_pkg::*;

    logic [ADDR_W-1:0] r_mem [MAX_LEN];
    logic [ADDR_W-1:0] r_rd;
    logic [ADDR_W-1:0] r_top;
    logic [ADDR_W-1:0] r_fwd_val;
    logic              r_fwd;
    logic [LEN_W-1:0]  r_depth;
    logic [LEN_W-1:0]  n_depth;
    logic [LEN_W-1:0]  wr_ptr;
    logic [LEN_W-1:0]  rd_ptr;
    logic              wr_en;
    logic [ADDR_W-1:0] below;

    // entry just under the top; forwarded when it was written at the last edge
    assign below  = r_fwd ? r_fwd_val : r_rd;
    assign wr_en  = i_ctl.push && (r_depth != '0);
    assign wr_ptr = r_depth - LEN_W'(1);

    always_comb begin
        n_depth = r_depth;
        if (i_ctl.clear) begin
            n_depth = '0;
        end else if (i_ctl.push) begin
            n_depth = r_depth + LEN_W'(1);
        end else if (i_ctl.pop) begin
            n_depth = r_depth - LEN_W'(1);
        end
    end

    assign rd_ptr = n_depth - LEN_W'(2);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_ptr[ADDR_W-1:0]] <= r_top;
        end
        r_rd <= r_mem[rd_ptr[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_fwd   <= 1'b0;
        end else begin
            r_depth <= n_depth;
            r_fwd   <= wr_en && !i_ctl.clear;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_val <= r_top;
        if (i_ctl.push) begin
            r_top <= i_ctl.data;
        end else if (i_ctl.pop) begin
            r_top <= below;
        end
    end

    assign o_top   = r_top;
    assign o_depth = r_depth;

endmodule

@@ design/dyck_word_match_finder_core.sv @@
// Top level of the parenthesis match finder: word memory, scan pipeline, output register.
`timescale 1ns / 1ps

// Usage:
//   Slave channel (i_s_*): one item per transfer. tuser is the command (0 append,
//   1 query). An append writes one parenthesis bit into the word memory unless
//   the word is full; it gives no result. A query scans the stored word from
//   position 0, one position per cycle through the word memory read port,
//   pushing and popping a position stack held in a second memory, and gives one
//   result on i_m/o_m_*. The scan stops early on a match or on an unmatched close.
//   A new item is taken only when no scan runs and no finished scan waits in the
//   hold register.
//   The result sits in an output register; while the receiver stalls, the block
//   still takes appends and the next query, and a finished scan waits in a hold
//   register until the output register frees up.
//   Configuration: i_cfg_we writes skip_period (0 = no separator slots); write
//   only while idle.
//   Reset (synchronous, active low) empties the word and the stack, clears
//   skip_period and drops any pending result. No clearing pass is needed.
module dyck_word_match_finder_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [0] paren_bit, [1] restart, [11:2] query_index, [15:12] zero
    input  logic [dwmf_pkg::S_DATA_W-1:0]     i_s_tdata,
    // [0] cmd
    input  logic                              i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [9:0] match_index, [15:10] zero
    output logic [dwmf_pkg::M_DATA_W-1:0]     o_m_tdata,
    input  logic                              i_cfg_we,
    input  logic [dwmf_pkg::SKIP_W-1:0]       i_cfg_wdata
);
    import dwmf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [SKIP_W-1:0] r_skip;
    logic [LEN_W-1:0]  r_len;
    logic [IDX_W-1:0]  r_query;
    logic [LEN_W-1:0]  r_pos;
    logic [SKIP_W-1:0] r_phase;
    logic [LEN_W-1:0]  r_cnt;
    logic              r_s1_valid;
    logic [ADDR_W-1:0] r_s1_cnt;
    logic              r_word_q;
    logic [IDX_W-1:0]  r_res;
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_data;
    logic              r_word_mem [MAX_LEN];

    logic              in_xfer;
    logic              is_query;
    logic              paren_bit;
    logic              restart;
    logic [IDX_W-1:0]  query_index;
    logic [LEN_W-1:0]  app_base;
    logic              app_wr;
    logic              issue;
    logic              slot;
    logic [SKIP_W-1:0] phase_inc;
    logic              done;
    logic [IDX_W-1:0]  res;
    logic              out_free;
    logic              load_out;
    logic [IDX_W-1:0]  load_val;
    t_stk_ctl          stk_ctl;
    logic [ADDR_W-1:0] stk_top;
    logic [LEN_W-1:0]  stk_depth;

    assign o_s_tready  = (r_state == ST_IDLE);
    assign in_xfer     = i_s_tvalid && o_s_tready;
    assign is_query    = (i_s_tuser == CMD_QUERY);
    assign paren_bit   = i_s_tdata[0];
    assign restart     = i_s_tdata[1];
    assign query_index = i_s_tdata[IDX_W+1:2];

    assign app_base = restart ? '0 : r_len;
    assign app_wr   = in_xfer && !is_query && (app_base < LEN_W'(MAX_LEN));

    // stage 0: address the word memory
    assign issue     = (r_state == ST_SCAN) && !done && (r_pos < r_len);
    assign slot      = (r_skip != '0) && (r_pos != '0) && (r_phase == '0);
    assign phase_inc = r_phase + SKIP_W'(1);

    always_ff @(posedge i_clk) begin
        if (app_wr) begin
            r_word_mem[app_base[ADDR_W-1:0]] <= paren_bit;
        end
        r_word_q <= r_word_mem[r_pos[ADDR_W-1:0]];
    end

    // stage 1: stack step on the bit read last cycle
    always_comb begin
        stk_ctl       = '0;
        stk_ctl.clear = in_xfer && is_query;
        stk_ctl.data  = r_s1_cnt;
        done          = 1'b0;
        res           = r_query;
        if (r_state == ST_SCAN) begin
            if (r_s1_valid) begin
                if (r_word_q) begin
                    stk_ctl.push = (stk_depth < LEN_W'(MAX_LEN));
                end else if (stk_depth == '0) begin
                    done = 1'b1;
                end else if (CNT_W'(r_query) == CNT_W'(stk_top)) begin
                    done = 1'b1;
                    res  = IDX_W'(r_s1_cnt);
                end else if (CNT_W'(r_query) == CNT_W'(r_s1_cnt)) begin
                    done = 1'b1;
                    res  = IDX_W'(stk_top);
                end else begin
                    stk_ctl.pop = 1'b1;
                end
            end else if (r_pos >= r_len) begin
                done = 1'b1;
            end
        end
    end

    dwmf_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (stk_ctl),
        .o_top   (stk_top),
        .o_depth (stk_depth)
    );

    assign out_free = !r_out_valid || i_m_tready;
    assign load_out = out_free && ((r_state == ST_HOLD) || ((r_state == ST_SCAN) && done));
    assign load_val = (r_state == ST_HOLD) ? r_res : res;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer && is_query) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (done) begin
                    n_state = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_skip      <= '0;
            r_len       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_skip <= i_cfg_wdata;
            end
            if (in_xfer && !is_query) begin
                r_len <= app_wr ? app_base + LEN_W'(1) : app_base;
            end
            r_s1_valid <= issue && !slot;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && is_query) begin
            r_query <= query_index;
            r_pos   <= '0;
            r_phase <= '0;
            r_cnt   <= '0;
        end else if (issue) begin
            r_pos    <= r_pos + LEN_W'(1);
            r_phase  <= (phase_inc == r_skip) ? '0 : phase_inc;
            r_cnt    <= slot ? r_cnt : r_cnt + LEN_W'(1);
            r_s1_cnt <= r_cnt[ADDR_W-1:0];
        end
        if ((r_state == ST_SCAN) && done) begin
            r_res <= res;
        end
        if (load_out) begin
            r_out_data <= load_val;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_DATA_W'(r_out_data);

    a_result_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> ($past(r_state) == ST_SCAN || $past(r_state) == ST_HOLD))
        else $error("result appeared without a finished scan");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(MAX_LEN))
        else $error("word length beyond capacity");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stk_depth <= LEN_W'(MAX_LEN))
        else $error("stack depth beyond capacity");

    a_query_starts_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && is_query) |=> (r_state == ST_SCAN && !r_s1_valid && stk_depth == '0))
        else $error("scan did not start from an empty pipeline and stack");

endmodule
